// File: hw/rtl/video_mode_filter_sort_top_defines.svh
// assertion macros for the display mode filter and sort block
`ifndef VIDEO_MODE_FILTER_SORT_TOP_DEFINES_SVH
`define VIDEO_MODE_FILTER_SORT_TOP_DEFINES_SVH

// same-cycle implication, checked on every rising clock edge out of reset
`define VMFS_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define VMFS_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: hw/rtl/vmfs_pkg.sv
// types and constants shared by the display mode filter and sort block
`timescale 1ns / 1ps

package vmfs_pkg;

   localparam int MAX_MODES = 64;
   localparam int IDX_W     = $clog2(MAX_MODES);
   localparam int CNT_W     = $clog2(MAX_MODES + 1);

   typedef struct packed {
      logic [15:0] mode_id;
      logic [15:0] attributes;
      logic [15:0] width_px;
      logic [15:0] height_px;
      logic [7:0]  depth_bits;
      logic        final_item;
   } req_word_type;

   typedef struct packed {
      logic [15:0] out_mode_id;
      logic [15:0] out_width_px;
      logic [15:0] out_height_px;
      logic [7:0]  out_depth_bits;
      logic        list_empty;
      logic        end_of_run;
   } rsp_word_type;

   typedef struct packed {
      logic [15:0] mode_id;
      logic [15:0] width_px;
      logic [15:0] height_px;
      logic [7:0]  depth_bits;
   } mode_entry_type;

   localparam int ENTRY_W = $bits(mode_entry_type);

   typedef enum logic [2:0] {
      ST_LOAD,
      ST_FETCH_I,
      ST_TAKE_I,
      ST_FETCH_J,
      ST_CMP_J,
      ST_SWAP,
      ST_EMIT,
      ST_EMPTY
   } sort_state_type;

   localparam logic [15:0] REQ_ATTR_RESET = 16'd153;

   // strict compare on (width, height, depth)
   function automatic logic key_greater(mode_entry_type a, mode_entry_type b);
      logic [39:0] ka;
      logic [39:0] kb;
      ka = {a.width_px, a.height_px, a.depth_bits};
      kb = {b.width_px, b.height_px, b.depth_bits};
      return ka > kb;
   endfunction

endpackage

// File: hw/rtl/vmfs_ram.sv
// generic single write port, single read port ram with registered read
`timescale 1ns / 1ps

module vmfs_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: hw/rtl/video_mode_filter_sort_top.sv
// display mode filter and sort: top level with load, sort and emit sequencer
//
// req channel: one mode word per cycle while loading (req_stall low). A mode
//   is kept when its attributes hold every bit of the csr register; at most
//   MAX_MODES are kept, later ones are dropped. final_item closes the list.
// after the final word req_stall stays high through sort and emit.
// sort: one selection pass per output position, one shared key comparator
//   and one ram read port; a pass at position i compares every later kept
//   mode with the best so far, then (but for the last pass) writes the mode
//   from i into the best mode's slot and shows the best mode on rsp.
// rsp channel: rsp_valid holds with a stable word until rsp_stall is low;
//   end_of_run marks the last word, an empty list gives one word with
//   list_empty and end_of_run set. loading resumes after the last word.
// csr channel: always ready; write only while loading with no list open.
// reset: synchronous, active high; clears the kept count, returns to
//   loading and sets the required attribute mask to 153. ram is not cleared.
`timescale 1ns / 1ps

`include "video_mode_filter_sort_top_defines.svh"

module video_mode_filter_sort_top (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  vmfs_pkg::req_word_type req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output vmfs_pkg::rsp_word_type rsp_data,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [15:0]           csr_data
);

   import vmfs_pkg::*;

   sort_state_type state_ff, state_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [CNT_W-1:0] n_ff, n_in;
   logic [CNT_W-1:0] j_ff, j_in;
   logic [IDX_W-1:0] i_ff, i_in;
   logic [IDX_W-1:0] best_idx_ff, best_idx_in;
   mode_entry_type   cur_ff, cur_in;
   mode_entry_type   best_ff, best_in;
   logic [15:0]      req_attr_ff, req_attr_in;

   logic                accept;
   logic                keep;
   logic [CNT_W-1:0]    n_total;
   logic [CNT_W-1:0]    i_next;
   logic                last_pass;
   logic                last_j;
   mode_entry_type      rd_entry;
   mode_entry_type      req_entry;
   logic                wr_en;
   logic [IDX_W-1:0]    wr_addr;
   logic [ENTRY_W-1:0]  wr_data;
   logic [IDX_W-1:0]    rd_addr;
   logic [ENTRY_W-1:0]  rd_data;

   assign accept    = req_valid & ~req_stall;
   assign keep      = ((req_data.attributes & req_attr_ff) == req_attr_ff) &&
                      (count_ff < CNT_W'(MAX_MODES));
   assign n_total   = count_ff + (keep ? CNT_W'(1) : CNT_W'(0));
   assign i_next    = CNT_W'(i_ff) + CNT_W'(1);
   assign last_pass = (i_next == n_ff);
   assign last_j    = ((j_ff + CNT_W'(1)) == n_ff);
   assign rd_entry  = mode_entry_type'(rd_data);
   assign req_entry = '{mode_id:    req_data.mode_id,
                        width_px:   req_data.width_px,
                        height_px:  req_data.height_px,
                        depth_bits: req_data.depth_bits};
   assign csr_ready = 1'b1;

   vmfs_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (MAX_MODES)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_LOAD: begin
            if (accept && req_data.final_item) begin
               state_in = (n_total == '0) ? ST_EMPTY : ST_FETCH_I;
            end
         end
         ST_FETCH_I: state_in = ST_TAKE_I;
         ST_TAKE_I:  state_in = last_pass ? ST_EMIT : ST_FETCH_J;
         ST_FETCH_J: state_in = ST_CMP_J;
         ST_CMP_J:   state_in = last_j ? ST_SWAP : ST_FETCH_J;
         ST_SWAP:    state_in = ST_EMIT;
         ST_EMIT: begin
            if (!rsp_stall) begin
               state_in = last_pass ? ST_LOAD : ST_FETCH_I;
            end
         end
         ST_EMPTY: begin
            if (!rsp_stall) begin
               state_in = ST_LOAD;
            end
         end
         default: state_in = ST_LOAD;
      endcase
   end

   // outputs and ram control
   always_comb begin
      req_stall = 1'b1;
      rsp_valid = 1'b0;
      rsp_data  = '0;
      wr_en     = 1'b0;
      wr_addr   = count_ff[IDX_W-1:0];
      wr_data   = ENTRY_W'(req_entry);
      rd_addr   = i_ff;
      case (state_ff)
         ST_LOAD: begin
            req_stall = 1'b0;
            wr_en     = req_valid & keep;
         end
         ST_FETCH_J: rd_addr = j_ff[IDX_W-1:0];
         ST_SWAP: begin
            wr_en   = 1'b1;
            wr_addr = best_idx_ff;
            wr_data = ENTRY_W'(cur_ff);
         end
         ST_EMIT: begin
            rsp_valid                = 1'b1;
            rsp_data.out_mode_id     = best_ff.mode_id;
            rsp_data.out_width_px    = best_ff.width_px;
            rsp_data.out_height_px   = best_ff.height_px;
            rsp_data.out_depth_bits  = best_ff.depth_bits;
            rsp_data.end_of_run      = last_pass;
         end
         ST_EMPTY: begin
            rsp_valid           = 1'b1;
            rsp_data.list_empty = 1'b1;
            rsp_data.end_of_run = 1'b1;
         end
         default: begin
            req_stall = 1'b1;
         end
      endcase
   end

   // datapath next values
   always_comb begin
      count_in    = count_ff;
      n_in        = n_ff;
      i_in        = i_ff;
      j_in        = j_ff;
      best_idx_in = best_idx_ff;
      cur_in      = cur_ff;
      best_in     = best_ff;
      req_attr_in = req_attr_ff;
      if (csr_valid && csr_ready) begin
         req_attr_in = csr_data;
      end
      case (state_ff)
         ST_LOAD: begin
            if (accept) begin
               count_in = n_total;
               if (req_data.final_item) begin
                  n_in     = n_total;
                  count_in = '0;
                  i_in     = '0;
               end
            end
         end
         ST_TAKE_I: begin
            cur_in      = rd_entry;
            best_in     = rd_entry;
            best_idx_in = i_ff;
            j_in        = i_next;
         end
         ST_CMP_J: begin
            if (key_greater(rd_entry, best_ff)) begin
               best_in     = rd_entry;
               best_idx_in = j_ff[IDX_W-1:0];
            end
            j_in = j_ff + CNT_W'(1);
         end
         ST_EMIT: begin
            if (!rsp_stall) begin
               i_in = i_next[IDX_W-1:0];
            end
         end
         default: begin
            j_in = j_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_LOAD;
         count_ff    <= '0;
         n_ff        <= '0;
         i_ff        <= '0;
         j_ff        <= '0;
         best_idx_ff <= '0;
         req_attr_ff <= REQ_ATTR_RESET;
      end else begin
         state_ff    <= state_in;
         count_ff    <= count_in;
         n_ff        <= n_in;
         i_ff        <= i_in;
         j_ff        <= j_in;
         best_idx_ff <= best_idx_in;
         req_attr_ff <= req_attr_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff  <= cur_in;
      best_ff <= best_in;
   end

   `VMFS_ASSERT_NOW(a_no_load_while_emit, rsp_valid, req_stall, "input taken while emitting")
   `VMFS_ASSERT_NOW(a_empty_is_last, rsp_valid && rsp_data.list_empty,
      rsp_data.end_of_run && rsp_data.out_width_px == 16'd0, "bad empty-list word")
   `VMFS_ASSERT_NOW(a_scan_in_range, state_ff == ST_CMP_J, j_ff < n_ff, "scan index past list")
   `VMFS_ASSERT_NEXT(a_final_closes, req_valid && !req_stall && req_data.final_item,
      req_stall && count_ff == '0, "list not closed after final word")

endmodule

// File: test/video_mode_filter_sort_checker.sv
// display mode filter and sort checker: predicts the sorted mode list and compares rsp words
`timescale 1ns / 1ps

module video_mode_filter_sort_checker (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic                   req_stall,
   input  vmfs_pkg::req_word_type req_data,
   input  logic                   rsp_valid,
   input  logic                   rsp_stall,
   input  vmfs_pkg::rsp_word_type rsp_data,
   input  logic                   csr_valid,
   input  logic                   csr_ready,
   input  logic [15:0]            csr_data,
   output int                     error_count,
   output int                     pending_words,
   output int                     words_checked
);

   import vmfs_pkg::*;

   mode_entry_type kept_modes [MAX_MODES];
   int             kept_total;
   logic [15:0]    attr_mask;
   rsp_word_type   sorted_words_q [$];

   function automatic logic [39:0] rank(input mode_entry_type m);
      return {m.width_px, m.height_px, m.depth_bits};
   endfunction

   // selection sort, descending, first strictly greater entry wins
   task automatic close_list();
      mode_entry_type held;
      rsp_word_type   word;
      int             best;
      word = '0;
      if (kept_total == 0) begin
         word.list_empty = 1'b1;
         word.end_of_run = 1'b1;
         sorted_words_q.push_back(word);
      end else begin
         for (int i = 0; i < kept_total; i++) begin
            best = i;
            for (int j = i + 1; j < kept_total; j++) begin
               if (rank(kept_modes[j]) > rank(kept_modes[best])) best = j;
            end
            if (best != i) begin
               held = kept_modes[i];
               kept_modes[i] = kept_modes[best];
               kept_modes[best] = held;
            end
         end
         for (int k = 0; k < kept_total; k++) begin
            word = '0;
            word.out_mode_id    = kept_modes[k].mode_id;
            word.out_width_px   = kept_modes[k].width_px;
            word.out_height_px  = kept_modes[k].height_px;
            word.out_depth_bits = kept_modes[k].depth_bits;
            word.end_of_run     = (k == kept_total - 1);
            sorted_words_q.push_back(word);
         end
      end
      kept_total = 0;
   endtask

   task automatic take_mode(input req_word_type word);
      if ((word.attributes & attr_mask) == attr_mask && kept_total < MAX_MODES) begin
         kept_modes[kept_total].mode_id    = word.mode_id;
         kept_modes[kept_total].width_px   = word.width_px;
         kept_modes[kept_total].height_px  = word.height_px;
         kept_modes[kept_total].depth_bits = word.depth_bits;
         kept_total++;
      end
      if (word.final_item) close_list();
   endtask

   task automatic check_word(input rsp_word_type got);
      rsp_word_type want;
      words_checked++;
      if (sorted_words_q.size() == 0) begin
         error_count++;
         if (error_count <= 10)
            $display("%0t: unexpected sorted word id %h w %0d h %0d bpp %0d empty %b end %b",
                     $realtime, got.out_mode_id, got.out_width_px, got.out_height_px,
                     got.out_depth_bits, got.list_empty, got.end_of_run);
      end else begin
         want = sorted_words_q.pop_front();
         if (got.out_mode_id !== want.out_mode_id || got.out_width_px !== want.out_width_px ||
             got.out_height_px !== want.out_height_px ||
             got.out_depth_bits !== want.out_depth_bits ||
             got.list_empty !== want.list_empty || got.end_of_run !== want.end_of_run) begin
            error_count++;
            if (error_count <= 10) begin
               $display("%0t: sorted word mismatch, expected id %h w %0d h %0d bpp %0d empty %b end %b",
                        $realtime, want.out_mode_id, want.out_width_px, want.out_height_px,
                        want.out_depth_bits, want.list_empty, want.end_of_run);
               $display("%0t:                       actual id %h w %0d h %0d bpp %0d empty %b end %b",
                        $realtime, got.out_mode_id, got.out_width_px, got.out_height_px,
                        got.out_depth_bits, got.list_empty, got.end_of_run);
            end
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         kept_total = 0;
         attr_mask = REQ_ATTR_RESET;
         sorted_words_q.delete();
         error_count = 0;
         words_checked = 0;
      end else begin
         if (rsp_valid && !rsp_stall) check_word(rsp_data);
         if (csr_valid && csr_ready) attr_mask = csr_data;
         if (req_valid && !req_stall) take_mode(req_data);
      end
      pending_words = sorted_words_q.size();
   end

endmodule

// File: test/testbench.sv
// display mode filter and sort testbench top: clock, reset, mode lists, mask writes and verdict
`timescale 1ns / 1ps

module testbench;

   import vmfs_pkg::*;

   localparam int QUIET_LIMIT = 5000;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_stall;
   req_word_type req_data = '0;
   logic         rsp_valid;
   logic         rsp_stall = 1'b0;
   rsp_word_type rsp_data;
   logic         csr_valid = 1'b0;
   logic         csr_ready;
   logic [15:0]  csr_data = '0;

   int          error_count;
   int          pending_words;
   int          words_checked;
   int          quiet_cycles = 0;
   int          burst_left = 0;
   int          lists_sent = 0;
   int          modes_sent = 0;
   int          masks_used = 0;
   int          stall_hold = 0;
   int          stall_style = 0;
   bit          steady_sender = 1'b0;
   logic [15:0] current_mask = REQ_ATTR_RESET;

   always #4 clock = ~clock;

   video_mode_filter_sort_top uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   video_mode_filter_sort_checker sort_check (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_data      (req_data),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_data      (rsp_data),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_data      (csr_data),
      .error_count   (error_count),
      .pending_words (pending_words),
      .words_checked (words_checked)
   );

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (csr_valid && csr_ready))
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("watchdog: no word moved for %0d cycles", QUIET_LIMIT);
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // receiver stall runs, style changes now and then
   always @(negedge clock) begin
      if (stall_hold == 0) begin
         if ($urandom_range(0, 15) == 0) stall_style = $urandom_range(0, 2);
         stall_hold = $urandom_range(1, 12);
         case (stall_style)
            0: rsp_stall <= 1'b0;
            1: rsp_stall <= ($urandom_range(0, 3) == 0);
            default: rsp_stall <= $urandom_range(0, 1);
         endcase
      end else begin
         stall_hold--;
      end
   end

   function automatic req_word_type mode_word(input logic [15:0] id, input logic [15:0] attr,
                                              input logic [15:0] w, input logic [15:0] h,
                                              input logic [7:0] bpp, input logic fin);
      req_word_type word;
      word.mode_id    = id;
      word.attributes = attr;
      word.width_px   = w;
      word.height_px  = h;
      word.depth_bits = bpp;
      word.final_item = fin;
      return word;
   endfunction

   // called at a falling edge, returns at the falling edge after acceptance
   task automatic put_mode(input req_word_type word);
      int gap;
      if (burst_left == 0) begin
         gap = steady_sender ? 0 : $urandom_range(0, 8);
         burst_left = $urandom_range(1, 16);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
      burst_left--;
      req_data  <= word;
      req_valid <= 1'b1;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
      modes_sent++;
      if (word.final_item) lists_sent++;
   endtask

   task automatic write_mask(input logic [15:0] mask);
      req_valid <= 1'b0;
      while (pending_words != 0) @(negedge clock);
      repeat (16) @(negedge clock);
      csr_data  <= mask;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
      current_mask = mask;
      masks_used++;
   endtask

   task automatic offer_list();
      req_word_type word;
      int           len;
      int           pick;
      int           k;
      bit           drop_all;
      pick = $urandom_range(0, 99);
      if (pick < 55) len = $urandom_range(1, 6);
      else if (pick < 80) len = $urandom_range(7, 20);
      else if (pick < 94) len = $urandom_range(21, 63);
      else len = $urandom_range(64, 72);
      drop_all = (current_mask != 16'h0000) && ($urandom_range(0, 11) == 0);
      steady_sender = ($urandom_range(0, 3) == 0);
      for (k = 0; k < len; k++) begin
         word.mode_id = 16'($urandom);
         if (drop_all) begin
            word.attributes = 16'($urandom) & ~current_mask;
         end else if ($urandom_range(0, 5) != 0) begin
            word.attributes = current_mask | 16'($urandom);
         end else begin
            word.attributes = 16'($urandom);
         end
         // small pools make equal keys common
         case ($urandom_range(0, 7))
            0: word.width_px = 16'd0;
            1: word.width_px = 16'hFFFF;
            2: word.width_px = 16'd640;
            3: word.width_px = 16'd1024;
            4: word.width_px = 16'd1920;
            default: word.width_px = 16'($urandom);
         endcase
         case ($urandom_range(0, 7))
            0: word.height_px = 16'd0;
            1: word.height_px = 16'hFFFF;
            2: word.height_px = 16'd480;
            3: word.height_px = 16'd768;
            4: word.height_px = 16'd1080;
            default: word.height_px = 16'($urandom);
         endcase
         case ($urandom_range(0, 7))
            0: word.depth_bits = 8'd0;
            1: word.depth_bits = 8'hFF;
            2: word.depth_bits = 8'd8;
            3: word.depth_bits = 8'd16;
            4: word.depth_bits = 8'd32;
            default: word.depth_bits = 8'($urandom);
         endcase
         word.final_item = (k == len - 1);
         put_mode(word);
      end
   endtask

   initial begin
      int round;
      repeat (12) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // reset mask: dropped modes, extremes, ties on width, height and depth
      put_mode(mode_word(16'd1, 16'hFFFF, 16'd640, 16'd480, 8'd8, 1'b0));
      put_mode(mode_word(16'd2, 16'h0099, 16'd640, 16'd480, 8'd32, 1'b0));
      put_mode(mode_word(16'd3, 16'h0098, 16'hFFFF, 16'hFFFF, 8'hFF, 1'b0));
      put_mode(mode_word(16'd4, 16'h0099, 16'hFFFF, 16'hFFFF, 8'hFF, 1'b0));
      put_mode(mode_word(16'd5, 16'hFF99, 16'd0, 16'd0, 8'd0, 1'b0));
      put_mode(mode_word(16'd6, 16'h0099, 16'd640, 16'd480, 8'd8, 1'b0));
      put_mode(mode_word(16'd7, 16'h0199, 16'd640, 16'd768, 8'd8, 1'b0));
      put_mode(mode_word(16'hFFFF, 16'h0099, 16'd640, 16'd480, 8'd8, 1'b1));
      // nothing kept
      put_mode(mode_word(16'd0, 16'h0000, 16'd1024, 16'd768, 8'd16, 1'b1));
      // kept mode closed by a dropped final word
      put_mode(mode_word(16'd10, 16'h6699, 16'd800, 16'd600, 8'd16, 1'b0));
      put_mode(mode_word(16'd11, 16'h0011, 16'd1920, 16'd1080, 8'd32, 1'b1));
      write_mask(16'hFFFF);
      put_mode(mode_word(16'd12, 16'hFFFF, 16'd1280, 16'd1024, 8'd24, 1'b0));
      put_mode(mode_word(16'd13, 16'h7FFF, 16'd1280, 16'd1024, 8'd32, 1'b1));
      write_mask(16'h0000);
      // equal keys reordered by the swap
      put_mode(mode_word(16'd20, 16'h0000, 16'd1024, 16'd768, 8'd16, 1'b0));
      put_mode(mode_word(16'd21, 16'h0000, 16'd1024, 16'd768, 8'd16, 1'b0));
      put_mode(mode_word(16'd22, 16'h0000, 16'd1024, 16'd768, 8'd32, 1'b1));
      put_mode(mode_word(16'd23, 16'h8000, 16'd1, 16'd1, 8'd1, 1'b1));

      round = 0;
      while (modes_sent < 330) begin
         if (round % 5 == 0) begin
            case ($urandom_range(0, 4))
               0: write_mask(16'h0000);
               1: write_mask(16'hFFFF);
               2: write_mask(REQ_ATTR_RESET);
               3: write_mask(16'($urandom));
               default: write_mask(16'(1 << $urandom_range(0, 15)));
            endcase
         end
         offer_list();
         round++;
      end

      req_valid <= 1'b0;
      while (pending_words != 0) @(negedge clock);
      repeat (50) @(negedge clock);

      $display("covered %0d mode lists, %0d mode words offered, %0d sorted words checked",
               lists_sent, modes_sent, words_checked);
      $display("attribute mask written %0d times, %0d errors", masks_used, error_count);
      if (error_count == 0 && pending_words == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
